/* design/aes_cmac_chained_iv_assert.svh */
// Assertion helpers shared by the RTL.
`ifndef AES_CMAC_CHAINED_IV_ASSERT_SVH
`define AES_CMAC_CHAINED_IV_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define AESC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition that must hold in the cycle after a reset cycle.
`define AESC_ASSERT_AFTER_RESET(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) !rst_n |=> (cond)) \
        else $error("assertion failed after reset");

`endif

/* design/aesc_pkg.sv */
package aesc_pkg;

    localparam int BlockW  = 128;
    localparam int HalfW   = 64;
    localparam int NBytes  = 16;
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);
    localparam int CntW    = 5;
    localparam int Rounds  = 10;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [1:0] CFG_SESSION  = 2'd2;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] DBL_POLY  = 8'h87;
    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       last;
    } t_req;

    typedef struct packed {
        logic valid;
        t_req req;
    } t_qhead;

    localparam t_byte SBOX_TAB [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic t_byte xt(input t_byte x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte 0 is the most significant byte of the block.
    function automatic t_byte get_byte(input logic [BlockW-1:0] v, input int idx);
        return v[BlockW-1-8*idx -: 8];
    endfunction

    function automatic logic [BlockW-1:0] key_expand(input logic [BlockW-1:0] rk,
                                                     input t_byte rcon);
        logic [31:0] w0, w1, w2, w3, tmp;
        w0  = rk[127:96];
        w1  = rk[95:64];
        w2  = rk[63:32];
        w3  = rk[31:0];
        tmp = {SBOX_TAB[w3[23:16]] ^ rcon, SBOX_TAB[w3[15:8]],
               SBOX_TAB[w3[7:0]], SBOX_TAB[w3[31:24]]};
        w0  = w0 ^ tmp;
        w1  = w1 ^ w0;
        w2  = w2 ^ w1;
        w3  = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [BlockW-1:0] aes_round(input logic [BlockW-1:0] s,
                                                    input logic [BlockW-1:0] rk,
                                                    input logic final_round);
        t_byte t [NBytes];
        t_byte a0, a1, a2, a3, all;
        logic [BlockW-1:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = SBOX_TAB[get_byte(s, i + 4*((c + i) % 4))];
            end
        end
        if (!final_round) begin
            for (int c = 0; c < 4; c++) begin
                a0  = t[4*c];
                a1  = t[4*c+1];
                a2  = t[4*c+2];
                a3  = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xt(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xt(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xt(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xt(a3 ^ a0);
            end
        end
        for (int i = 0; i < NBytes; i++) begin
            r[BlockW-1-8*i -: 8] = t[i];
        end
        return r ^ rk;
    endfunction

    // Multiply by x in GF(2^128) for subkey derivation.
    function automatic logic [BlockW-1:0] gf_dbl(input logic [BlockW-1:0] v);
        return {v[BlockW-2:0], 1'b0} ^ {{(BlockW-8){1'b0}}, (v[BlockW-1] ? DBL_POLY : 8'h00)};
    endfunction

endpackage

/* design/aesc_front.sv */
module aesc_front
    import aesc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_session_active,
    input  logic       i_push,
    input  logic [1:0] i_command,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    output logic       o_full,
    output t_qhead     o_head,
    input  logic       i_pop
);

    t_req              r_mem [QDepth];
    logic [QPtrW-1:0]  r_wptr;
    logic [QPtrW-1:0]  r_rptr;
    logic [QPtrW:0]    r_count;
    logic              w_accept;
    logic              w_keep;
    logic              w_wr;
    logic              w_rd;
    t_req              w_req;

    assign o_full   = (r_count == (QPtrW+1)'(QDepth));
    assign w_accept = i_push && !o_full;

    // Drop requests while the session is off, and unused command codes.
    always_comb begin
        w_req.data_byte = i_data_byte;
        w_req.last      = 1'b0;
        w_keep          = i_session_active;
        case (i_command)
            CMD_BYTE: begin
                w_req.op   = OP_BYTE;
                w_req.last = i_last;
            end
            CMD_CLOSE: w_req.op = OP_CLOSE;
            CMD_CLEAR: w_req.op = OP_CLEAR;
            default: begin
                w_req.op = OP_CLEAR;
                w_keep   = 1'b0;
            end
        endcase
    end

    assign w_wr = w_accept && w_keep;
    assign w_rd = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (QPtrW+1)'(w_wr) - (QPtrW+1)'(w_rd);
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_mem[r_rptr];

endmodule

/* design/aesc_aes.sv */
module aesc_aes
    import aesc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [BlockW-1:0] i_block,
    input  logic [BlockW-1:0] i_key,
    output logic              o_done,
    output logic [BlockW-1:0] o_result
);

    logic              r_busy;
    logic              r_done;
    logic [3:0]        r_round;
    t_byte             r_rcon;
    logic [BlockW-1:0] r_state;
    logic [BlockW-1:0] r_rk;
    logic [BlockW-1:0] w_rk_next;
    logic              w_final;

    assign w_rk_next = key_expand(r_rk, r_rcon);
    assign w_final   = (r_round == 4'(Rounds));

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_state <= i_block ^ i_key;
            r_rk    <= i_key;
            r_rcon  <= RCON_INIT;
        end else if (r_busy) begin
            r_state <= aes_round(r_state, w_rk_next, w_final);
            r_rk    <= w_rk_next;
            r_rcon  <= xt(r_rcon);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= r_busy && w_final;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= 4'd1;
            end else if (r_busy) begin
                r_round <= r_round + 4'd1;
                if (w_final) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_state;

endmodule

/* design/aesc_back.sv */
module aesc_back
    import aesc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_qhead            i_head,
    output logic              o_pop,
    input  logic [BlockW-1:0] i_key,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [BlockW-1:0] o_mac
);

    typedef enum logic [2:0] {
        ST_PLAN = 3'b001,
        ST_AES  = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        PUR_SUBKEY = 2'd0,
        PUR_CHAIN  = 2'd1,
        PUR_FINAL  = 2'd2
    } t_purpose;

    t_state            r_state, n_state;
    t_purpose          r_purpose, n_purpose;
    t_req              r_cur, n_cur;
    logic              r_cur_valid, n_cur_valid;
    logic              r_stored, n_stored;
    logic [BlockW-1:0] r_chain, n_chain;
    logic [BlockW-1:0] r_run, n_run;
    logic [BlockW-1:0] r_k1, n_k1;
    logic [BlockW-1:0] r_k2, n_k2;
    logic [CntW-1:0]   r_count, n_count;
    logic              r_open, n_open;
    logic              r_out_valid, n_out_valid;
    logic [BlockW-1:0] r_mac, n_mac;
    t_byte             r_buf [NBytes];

    logic              w_buf_we;
    logic              w_done;
    logic              w_aes_start;
    logic [BlockW-1:0] w_aes_block;
    logic              w_aes_done;
    logic [BlockW-1:0] w_aes_out;
    logic [BlockW-1:0] w_full_blk;
    logic [BlockW-1:0] w_last_blk;

    aesc_aes u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_aes_start),
        .i_block  (w_aes_block),
        .i_key    (i_key),
        .o_done   (w_aes_done),
        .o_result (w_aes_out)
    );

    // Whole buffer, and the padded final block.
    always_comb begin
        for (int i = 0; i < NBytes; i++) begin
            w_full_blk[BlockW-1-8*i -: 8] = r_buf[i];
            if (CntW'(i) < r_count) begin
                w_last_blk[BlockW-1-8*i -: 8] = r_buf[i];
            end else if (CntW'(i) == r_count) begin
                w_last_blk[BlockW-1-8*i -: 8] = PAD_BYTE;
            end else begin
                w_last_blk[BlockW-1-8*i -: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_purpose   = r_purpose;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_stored    = r_stored;
        n_chain     = r_chain;
        n_run       = r_run;
        n_k1        = r_k1;
        n_k2        = r_k2;
        n_count     = r_count;
        n_open      = r_open;
        n_out_valid = r_out_valid;
        n_mac       = r_mac;
        w_buf_we    = 1'b0;
        w_done      = 1'b0;
        w_aes_start = 1'b0;
        w_aes_block = '0;
        o_pop       = 1'b0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_PLAN: begin
                if (r_cur_valid) begin
                    if (r_cur.op == OP_CLEAR) begin
                        n_chain = '0;
                        w_done  = 1'b1;
                    end else if (!r_open) begin
                        w_aes_start = 1'b1;
                        n_purpose   = PUR_SUBKEY;
                        n_state     = ST_AES;
                    end else if (r_cur.op == OP_BYTE && !r_stored
                                 && r_count == CntW'(NBytes)) begin
                        w_aes_start = 1'b1;
                        w_aes_block = r_run ^ w_full_blk;
                        n_purpose   = PUR_CHAIN;
                        n_state     = ST_AES;
                    end else if (r_cur.op == OP_BYTE && !r_stored) begin
                        w_buf_we = 1'b1;
                        n_count  = r_count + 1'b1;
                        n_stored = 1'b1;
                        w_done   = !r_cur.last;
                    end else begin
                        w_aes_start = 1'b1;
                        w_aes_block = r_run ^ w_last_blk
                                    ^ ((r_count == CntW'(NBytes)) ? r_k1 : r_k2);
                        n_purpose   = PUR_FINAL;
                        n_state     = ST_AES;
                    end
                end
                // Take the next request in the same cycle the current one retires.
                if ((!r_cur_valid || w_done) && i_head.valid) begin
                    n_cur       = i_head.req;
                    n_cur_valid = 1'b1;
                    n_stored    = 1'b0;
                    o_pop       = 1'b1;
                end else if (w_done) begin
                    n_cur_valid = 1'b0;
                end
            end
            ST_AES: begin
                if (w_aes_done) begin
                    case (r_purpose)
                        PUR_SUBKEY: begin
                            n_k1    = gf_dbl(w_aes_out);
                            n_k2    = gf_dbl(gf_dbl(w_aes_out));
                            n_run   = r_chain;
                            n_count = '0;
                            n_open  = 1'b1;
                            n_state = ST_PLAN;
                        end
                        PUR_CHAIN: begin
                            n_run   = w_aes_out;
                            n_count = '0;
                            n_state = ST_PLAN;
                        end
                        PUR_FINAL: begin
                            n_chain = w_aes_out;
                            n_state = ST_OUT;
                        end
                        default: n_state = ST_PLAN;
                    endcase
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_mac       = r_chain;
                    n_open      = 1'b0;
                    n_count     = '0;
                    n_cur_valid = 1'b0;
                    n_state     = ST_PLAN;
                end
            end
            default: n_state = ST_PLAN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_buf[r_count[3:0]] <= r_cur.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_purpose <= n_purpose;
        r_k1      <= n_k1;
        r_k2      <= n_k2;
        r_mac     <= n_mac;
        r_stored  <= n_stored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_PLAN;
            r_cur_valid <= 1'b0;
            r_chain     <= '0;
            r_run       <= '0;
            r_count     <= '0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_valid <= n_cur_valid;
            r_chain     <= n_chain;
            r_run       <= n_run;
            r_count     <= n_count;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_mac   = r_mac;

endmodule

/* design/aes_cmac_chained_iv.sv */
// Throughput: one request per cycle into a 4-deep request queue while it is not full;
//   message bytes retire one per cycle in the back end except while the AES round unit is busy.
// A close runs one AES encryption from its dequeue to the MAC; the first request of a message
//   first derives the subkeys through the same AES round unit.
// Reset (synchronous, active low): clears the queue, chaining value, key and session flag.
module aes_cmac_chained_iv
    import aesc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [HalfW-1:0]  i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last,
    output logic              empty,
    input  logic              pop,
    output logic [HalfW-1:0]  o_mac_high,
    output logic [HalfW-1:0]  o_mac_low
);

`include "aes_cmac_chained_iv_assert.svh"

    logic [HalfW-1:0]  r_key_high;
    logic [HalfW-1:0]  r_key_low;
    logic              r_session_active;
    t_qhead            w_head;
    logic              w_q_pop;
    logic [BlockW-1:0] w_mac;

    // Configuration writes; unused indexes drop silently.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high       <= '0;
            r_key_low        <= '0;
            r_session_active <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high       <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low        <= i_cfg_data;
                CFG_SESSION:  r_session_active <= i_cfg_data[0];
                default:      r_session_active <= r_session_active;
            endcase
        end
    end

    // Front end: accept, classify, queue each request.
    aesc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_session_active (r_session_active),
        .i_push           (push),
        .i_command        (i_command),
        .i_data_byte      (i_data_byte),
        .i_last           (i_last),
        .o_full           (full),
        .o_head           (w_head),
        .i_pop            (w_q_pop)
    );

    // Back end: buffer bytes, fold blocks, derive subkeys, finish the MAC.
    aesc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_q_pop),
        .i_key   ({r_key_high, r_key_low}),
        .o_empty (empty),
        .i_pop   (pop),
        .o_mac   (w_mac)
    );

    assign o_mac_high = w_mac[BlockW-1:HalfW];
    assign o_mac_low  = w_mac[HalfW-1:0];

    `AESC_ASSERT_IMPLY(a_pop_needs_head, i_clk, i_rst_n, w_q_pop, w_head.valid)
    `AESC_ASSERT_AFTER_RESET(a_reset_no_result, i_clk, i_rst_n, empty && !w_head.valid)

endmodule

/* tb/sv/aes_cmac_chained_iv_tb.sv */
module aes_cmac_chained_iv_tb;
    import aesc_pkg::*;

    // Command code that the block must ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Cycles to let the block drain work that gives no result.
    localparam int DRAIN_CYCLES = 80;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [HalfW-1:0]  i_cfg_data;
    logic              push;
    logic              full;
    logic [1:0]        i_command;
    logic [7:0]        i_data_byte;
    logic              i_last;
    logic              empty;
    logic              pop;
    logic [HalfW-1:0]  o_mac_high;
    logic [HalfW-1:0]  o_mac_low;

    aes_cmac_chained_iv u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .empty       (empty),
        .pop         (pop),
        .o_mac_high  (o_mac_high),
        .o_mac_low   (o_mac_low)
    );

    // Mirror of the block state used to predict MACs.
    logic [BlockW-1:0] mdl_key;
    logic              mdl_active;
    logic [BlockW-1:0] mdl_chain;
    logic [BlockW-1:0] mdl_run;
    logic [7:0]        mdl_buf [NBytes];
    int                mdl_cnt;
    logic              mdl_open;
    logic [BlockW-1:0] mdl_k1;
    logic [BlockW-1:0] mdl_k2;

    logic [BlockW-1:0] mac_expected [$];
    int                mismatches;
    int                sent_n;
    bit                tx_calm;
    bit                rx_calm;

    typedef struct {
        logic [1:0]        cmd;
        logic [7:0]        data;
        logic              last;
        bit                typed;
        logic [BlockW-1:0] mac;
    } t_dir_row;

    t_dir_row dir_tab [25];

    // Double in GF(2^8).
    function automatic logic [7:0] gf_x2(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES-128 block encryption, bytes big-endian within the vectors.
    function automatic logic [BlockW-1:0] aes128_encrypt(input logic [BlockW-1:0] key,
                                                         input logic [BlockW-1:0] pt);
        logic [7:0] w [176];
        logic [7:0] st [16];
        logic [7:0] t [16];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, s, tmp;
        logic [7:0] v0, v1, v2, v3;
        logic [BlockW-1:0] ct;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) begin
            w[i]  = key[127-8*i -: 8];
            st[i] = pt[127-8*i -: 8] ^ w[i];
        end
        for (int i = 16; i < 176; i += 4) begin
            v0 = w[i-4]; v1 = w[i-3]; v2 = w[i-2]; v3 = w[i-1];
            if (i % 16 == 0) begin
                tmp = v0;
                v0  = SBOX_TAB[v1] ^ rc;
                v1  = SBOX_TAB[v2];
                v2  = SBOX_TAB[v3];
                v3  = SBOX_TAB[tmp];
                rc  = gf_x2(rc);
            end
            w[i]   = w[i-16] ^ v0;
            w[i+1] = w[i-15] ^ v1;
            w[i+2] = w[i-14] ^ v2;
            w[i+3] = w[i-13] ^ v3;
        end
        for (int r = 1; r <= 10; r++) begin
            // SubBytes and ShiftRows together
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    t[i + 4*c] = SBOX_TAB[st[i + 4*((c + i) % 4)]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    s  = a0 ^ a1 ^ a2 ^ a3;
                    t[4*c]   = a0 ^ s ^ gf_x2(a0 ^ a1);
                    t[4*c+1] = a1 ^ s ^ gf_x2(a1 ^ a2);
                    t[4*c+2] = a2 ^ s ^ gf_x2(a2 ^ a3);
                    t[4*c+3] = a3 ^ s ^ gf_x2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = t[i] ^ w[16*r + i];
        end
        for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = st[i];
        return ct;
    endfunction

    function automatic logic [BlockW-1:0] times_x(input logic [BlockW-1:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
    endfunction

    function automatic logic [BlockW-1:0] buf_block(input int n);
        logic [BlockW-1:0] b;
        b = '0;
        for (int i = 0; i < n; i++) b[127-8*i -: 8] = mdl_buf[i];
        return b;
    endfunction

    // Start a message: derive subkeys under the present key, seed the chain.
    task automatic open_message();
        logic [BlockW-1:0] l;
        l = aes128_encrypt(mdl_key, '0);
        mdl_k1   = times_x(l);
        mdl_k2   = times_x(mdl_k1);
        mdl_run  = mdl_chain;
        mdl_cnt  = 0;
        mdl_open = 1'b1;
    endtask

    // Close the message and return its MAC; the MAC becomes the new chain.
    task automatic close_message(output logic [BlockW-1:0] mac);
        logic [BlockW-1:0] blk;
        blk = buf_block(mdl_cnt);
        if (mdl_cnt == 16) begin
            blk = blk ^ mdl_k1;
        end else begin
            blk[127-8*mdl_cnt -: 8] = PAD_BYTE;
            blk = blk ^ mdl_k2;
        end
        mac       = aes128_encrypt(mdl_key, mdl_run ^ blk);
        mdl_chain = mac;
        mdl_cnt   = 0;
        mdl_open  = 1'b0;
    endtask

    // Advance the mirror by one accepted request; returns 1 with a MAC.
    task automatic predict_mac(input logic [1:0] cmd, input logic [7:0] data,
                               input logic last, output bit got, output logic [BlockW-1:0] mac);
        got = 0;
        mac = '0;
        if (!mdl_active) return;
        case (cmd)
            CMD_BYTE: begin
                if (!mdl_open) open_message();
                if (mdl_cnt >= 16) begin
                    mdl_run = aes128_encrypt(mdl_key, mdl_run ^ buf_block(16));
                    mdl_cnt = 0;
                end
                mdl_buf[mdl_cnt] = data;
                mdl_cnt++;
                if (last) begin
                    close_message(mac);
                    got = 1;
                end
            end
            CMD_CLOSE: begin
                if (!mdl_open) open_message();
                close_message(mac);
                got = 1;
            end
            CMD_CLEAR: mdl_chain = '0;
            default: ;
        endcase
    endtask

    // Present one request, hold it until accepted, then advance the mirror.
    // Returns after the accepting edge with push still high.
    task automatic send_req(input logic [1:0] cmd, input logic [7:0] data, input logic last,
                            input bit typed, input logic [BlockW-1:0] typed_mac);
        int gap;
        bit got;
        bit taken;
        logic [BlockW-1:0] mac;
        gap = tx_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_command   <= cmd;
        i_data_byte <= data;
        i_last      <= last;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end
        predict_mac(cmd, data, last, got, mac);
        if (got) mac_expected.push_back(typed ? typed_mac : mac);
        sent_n++;
    endtask

    // Drop push, wait for every expected MAC, then let background work settle.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (mac_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then drop the enable again before returning.
    task automatic write_reg(input logic [1:0] idx, input logic [HalfW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_KEY_HIGH: mdl_key[127:64] = val;
            CFG_KEY_LOW:  mdl_key[63:0]   = val;
            CFG_SESSION:  mdl_active      = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // One well-formed message with random content and length.
    task automatic send_message();
        int len;
        int sel;
        bit late_close;
        sel = $urandom_range(0, 9);
        case (sel)
            0: len = 0;
            1: len = 16;
            2: len = 32;
            3: len = $urandom_range(33, 64);
            default: len = $urandom_range(1, 20);
        endcase
        late_close = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_req(CMD_BYTE, 8'($urandom_range(0, 255)),
                     (i == len - 1) && !late_close, 1'b0, '0);
        if (len == 0 || late_close)
            send_req(CMD_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'b0, '0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // Result side: stall at random, compare each accepted MAC with the oldest expectation.
    initial begin
        int stall;
        bit taken;
        logic [BlockW-1:0] want;
        pop <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            taken = 0;
            while (!taken) begin
                @(negedge i_clk);
                if (!empty) begin
                    taken = 1;
                    if (mac_expected.size() == 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected MAC %h %h", o_mac_high, o_mac_low);
                    end else begin
                        want = mac_expected.pop_front();
                        if (o_mac_high !== want[127:64] || o_mac_low !== want[63:0]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("MAC mismatch: expected %h %h, got %h %h",
                                         want[127:64], want[63:0], o_mac_high, o_mac_low);
                        end
                    end
                end
                @(posedge i_clk);
            end
        end
    end

    // Request side: directed table, then random phases under changing keys.
    initial begin
        int target;
        int limit;
        logic [HalfW-1:0] kh, kl;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_KEY_HIGH;
        i_cfg_data  <= '0;
        push        <= 1'b0;
        i_command   <= CMD_BYTE;
        i_data_byte <= '0;
        i_last      <= 1'b0;
        mdl_key = '0; mdl_active = 0; mdl_chain = '0; mdl_run = '0;
        mdl_cnt = 0; mdl_open = 0; mdl_k1 = '0; mdl_k2 = '0;
        mismatches = 0; sent_n = 0; tx_calm = 0; rx_calm = 0;
        for (int i = 0; i < NBytes; i++) mdl_buf[i] = '0;

        // Session off: the first three rows must give nothing. Then the standard
        // CMAC vectors: empty message, and one complete block from a cleared chain.
        dir_tab = '{
            '{CMD_BYTE,   8'hff, 1'b1, 0, '0},
            '{CMD_CLOSE,  8'h00, 1'b0, 0, '0},
            '{CMD_CLEAR,  8'h00, 1'b1, 0, '0},
            '{CMD_CLOSE,  8'h00, 1'b1, 1, 128'hbb1d6929e95937287fa37d129b756746},
            '{CMD_CLEAR,  8'h00, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h6b, 1'b0, 0, '0},
            '{CMD_BYTE,   8'hc1, 1'b0, 0, '0},
            '{CMD_BYTE,   8'hbe, 1'b0, 0, '0},
            '{CMD_BYTE,   8'he2, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h2e, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h40, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h9f, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h96, 1'b0, 0, '0},
            '{CMD_BYTE,   8'he9, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h3d, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h7e, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h11, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h73, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h93, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h17, 1'b0, 0, '0},
            '{CMD_BYTE,   8'h2a, 1'b1, 1, 128'h070a16b46b4d4144f79bdd9dd04a287c},
            '{CMD_UNUSED, 8'hff, 1'b1, 0, '0},
            '{CMD_BYTE,   8'h00, 1'b0, 0, '0},
            '{CMD_CLEAR,  8'hff, 1'b1, 0, '0},
            '{CMD_BYTE,   8'hff, 1'b1, 0, '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 25; i++) begin
            if (i == 3) begin
                // Session on with the standard test key.
                wait_idle();
                write_reg(CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
                write_reg(CFG_KEY_LOW, 64'habf7158809cf4f3c);
                write_reg(CFG_SESSION, 64'd1);
            end
            send_req(dir_tab[i].cmd, dir_tab[i].data, dir_tab[i].last,
                     dir_tab[i].typed, dir_tab[i].mac);
        end

        // Random phases; a phase may end mid-message, so key changes and session
        // drops also land inside open messages.
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            kh = {$urandom, $urandom};
            kl = {$urandom, $urandom};
            if (ph == 0) begin
                kh = '0; kl = '0;
            end else if (ph == 1) begin
                kh = '1; kl = '1;
            end
            write_reg(CFG_KEY_HIGH, kh);
            write_reg(CFG_KEY_LOW, kl);
            write_reg(CFG_SESSION, (ph == 4) ? 64'd0 : {$urandom, $urandom} | 64'd1);
            tx_calm = ($urandom_range(0, 3) == 0);
            limit   = (ph == 4) ? 30 : 210;
            target  = sent_n + limit;
            while (sent_n < target) begin
                if (sent_n > target - limit / 2 && sent_n < target - limit / 2 + 3) begin
                    // hold off until every pending MAC has drained
                    push <= 1'b0;
                    @(posedge i_clk);
                    while (mac_expected.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(0, 9) < 7)
                    send_message();
                else
                    send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'b0, '0);
                if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
            end
        end

        wait_idle();
        if (mismatches == 0 && mac_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
